FILE: src/wfsf_pkg.sv
// wfsf_pkg: types and constants shared by the seen-frame filter.
// Used by wfsf_ctrl, wfsf_datapath and wlan_frame_seen_filter; no dependencies.
package wfsf_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int NAME_BYTES  = 32;
  localparam int NAME_BITS   = NAME_BYTES * 8;

  // Field widths
  localparam int KIND_W = 3;
  localparam int ADDR_W = 48;
  localparam int LEN_W  = 6;
  localparam int WORD_W = 64;

  // Input beat
  typedef struct packed {
    logic [KIND_W-1:0] frame_kind;
    logic [ADDR_W-1:0] ap_address;
    logic [LEN_W-1:0]  ssid_length;
    logic [WORD_W-1:0] ssid_word0;
    logic [WORD_W-1:0] ssid_word1;
    logic [WORD_W-1:0] ssid_word2;
    logic [WORD_W-1:0] ssid_word3;
  } in_t;

  // Result beat
  typedef struct packed {
    logic is_new;
    logic was_flushed;
  } out_t;

  // One stored table row
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [ADDR_W-1:0]    address;
    logic [LEN_W-1:0]     length;
    logic [NAME_BITS-1:0] name;
  } entry_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_STORE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the frame, restart the walk
    logic issue;     // read the entry at the walk index
    logic emit_hit;  // report a match
    logic store;     // append the frame and report it as new
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;       // entry read last cycle matches
    logic scan_end;  // every filled entry has been read
  } status_t;

endpackage

FILE: src/wfsf_ctrl.sv
// wfsf_ctrl: state machine that sequences the table walk and the append.
// Depends on wfsf_pkg.
module wfsf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  wfsf_pkg::status_t status,
  output wfsf_pkg::cmd_t    cmd,
  output logic              busy
);
  import wfsf_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // compare the entry read last cycle, issue the next one
        if (status.hit) begin
          cmd.emit_hit = 1'b1;
          state_next   = S_IDLE;
        end else if (status.scan_end) begin
          state_next = S_STORE;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: src/wfsf_datapath.sv
// wfsf_datapath: frame register, entry table memory, walk index, fill count,
// entry compare and result register. Depends on wfsf_pkg.
module wfsf_datapath (
  input  logic              clk,
  input  logic              rst,
  input  wfsf_pkg::in_t     frame,
  input  wfsf_pkg::cmd_t    cmd,
  output wfsf_pkg::status_t status,
  output logic              done,
  output wfsf_pkg::out_t    result
);
  import wfsf_pkg::*;

  entry_t               table_mem [TABLE_DEPTH];
  entry_t               cur;        // captured frame
  logic [NAME_BYTES-1:0] byte_mask; // name bytes that take part in the compare
  logic [NAME_BYTES-1:0] byte_mask_next;
  entry_t               rd_data;
  logic                 rd_valid;
  logic [CNT_W-1:0]     rd_idx;
  logic [CNT_W-1:0]     fill_count;
  logic                 full;
  logic [IDX_W-1:0]     slot;
  logic                 name_eq;
  logic [WORD_W*4-1:0]  name_in;

  assign name_in = {frame.ssid_word3, frame.ssid_word2, frame.ssid_word1, frame.ssid_word0};

  // Byte i is compared when i is below the frame's length
  always_comb begin
    for (int i = 0; i < NAME_BYTES; i++) begin
      byte_mask_next[i] = (LEN_W'(i) < frame.ssid_length);
    end
  end

  // Frame capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur.kind    <= frame.frame_kind;
      cur.address <= frame.ap_address;
      cur.length  <= frame.ssid_length;
      cur.name    <= name_in[NAME_BITS-1:0];
      byte_mask   <= byte_mask_next;
    end
  end

  // Table memory: one read or one write a cycle, registered read data
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      table_mem[slot] <= cur;
    end
    if (cmd.issue) begin
      rd_data <= table_mem[rd_idx[IDX_W-1:0]];
    end
  end

  // Walk index and read-pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
      if (cmd.load) begin
        rd_idx <= '0;
      end else if (cmd.issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  // Fill count; a full table restarts at slot 0
  assign full = (fill_count == CNT_W'(TABLE_DEPTH));
  assign slot = full ? '0 : fill_count[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.store) begin
      fill_count <= {1'b0, slot} + 1'b1;
    end
  end

  // Entry compare on the registered read data
  always_comb begin
    name_eq = 1'b1;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (byte_mask[i] && (rd_data.name[i*8 +: 8] != cur.name[i*8 +: 8])) begin
        name_eq = 1'b0;
      end
    end
  end

  assign status.hit = rd_valid && (rd_data.kind == cur.kind) &&
                      (rd_data.address == cur.address) &&
                      (rd_data.length == cur.length) && name_eq;
  assign status.scan_end = (rd_idx == fill_count);

  // Result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_hit | cmd.store;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hit | cmd.store) begin
      result.is_new      <= cmd.store;
      result.was_flushed <= cmd.store & full;
    end
  end

endmodule

FILE: src/wlan_frame_seen_filter.sv
// Seen-frame filter for wireless management frame summaries: at most
// TABLE_DEPTH (1024) entries are walked in order for each frame. A frame is
// taken when start is high and busy is low; a new frame is appended after
// every filled entry has been read, while a match stops the walk early. The
// walk rate is set by the single-port entry memory, read one entry per cycle.
// The answer appears on result for exactly one cycle with done high; the
// receiver cannot stall it, and the block is ready for the next frame in that
// same cycle. The table is empty after reset with no clearing pass.
// Depends on wfsf_pkg, wfsf_ctrl, wfsf_datapath.
module wlan_frame_seen_filter (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  wfsf_pkg::in_t  frame,
  output logic           done,
  output wfsf_pkg::out_t result
);
  import wfsf_pkg::*;

  cmd_t    cmd;
  status_t status;

  wfsf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  wfsf_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame),
    .cmd    (cmd),
    .status (status),
    .done   (done),
    .result (result)
  );

endmodule
